// ===== sv/bdf_pkg.sv =====
// Shared types, constants and helper functions for the block record deframer.
// Used by every module of the block; depends on nothing else.
package bdf_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 32;
    localparam int unsigned KindW = 2;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned NumMagics = 3;

    // Bytes held between items; the eighth byte of a window is the incoming one.
    localparam int unsigned WinHeld = 7;
    localparam int unsigned FillW = $clog2(WinHeld + 1);

    localparam logic [CfgIndexW-1:0] CfgFileLength = CfgIndexW'(0);
    localparam logic [CfgIndexW-1:0] CfgMaxPayload = CfgIndexW'(1);

    localparam logic [WordW-1:0] FileLengthReset = 32'd0;
    localparam logic [WordW-1:0] MaxPayloadReset = 32'd2000000;
    localparam logic [WordW-1:0] PosMax = 32'hFFFF_FFFF;

    localparam logic [KindW-1:0] KindNone = 2'd3;

    // Magic words, first file byte in the most significant byte.
    localparam logic [WordW-1:0] MagicTab [NumMagics] = '{
        32'h24e9_2764,
        32'hfa1a_f9bf,
        32'haae8_3f5f
    };

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             file_start;
    } bdf_item_t;

    typedef struct packed {
        logic [WordW-1:0] payload_offset;
        logic [WordW-1:0] payload_length;
        logic [KindW-1:0] magic_kind;
    } bdf_rec_t;

    typedef struct packed {
        logic     emit;
        bdf_rec_t rec;
    } bdf_scan_out_t;

    // Returns the index of the first matching magic, or KindNone.
    function automatic logic [KindW-1:0] match_magic(input logic [WordW-1:0] head);
        logic [KindW-1:0] kind;
        kind = KindNone;
        for (int k = NumMagics - 1; k >= 0; k--)
        begin
            if (head == MagicTab[k])
            begin
                kind = KindW'(k);
            end
        end
        return kind;
    endfunction

endpackage

// ===== sv/bdf_in_stage.sv =====
// Input register of the deframer: holds one accepted byte item until the
// scanner takes it. Depends on bdf_pkg.
module bdf_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               take,
    input  bdf_pkg::bdf_item_t item_in,
    output logic               valid,
    output bdf_pkg::bdf_item_t item_out
);
    import bdf_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    bdf_item_t item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// ===== sv/bdf_scan.sv =====
// Scanner of the deframer: configuration registers, window, position and skip
// state, and the combinational header check. Depends on bdf_pkg.
module bdf_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bdf_pkg::CfgIndexW-1:0]  cfg_index,
    input  logic [bdf_pkg::WordW-1:0]      cfg_data,
    input  logic                           go,
    input  bdf_pkg::bdf_item_t             item,
    output bdf_pkg::bdf_scan_out_t         scan_out
);
    import bdf_pkg::*;

    logic [WordW-1:0] file_length_reg;
    logic [WordW-1:0] max_payload_reg;
    logic [ByteW-1:0] win_reg  [WinHeld];
    logic [ByteW-1:0] win_next [WinHeld];
    logic [FillW-1:0] fill_reg;
    logic [FillW-1:0] fill_next;
    logic [WordW-1:0] pos_reg;
    logic [WordW-1:0] pos_next;
    logic [WordW-1:0] skip_reg;
    logic [WordW-1:0] skip_next;

    logic [FillW-1:0] fill_cur;
    logic [WordW-1:0] pos_cur;
    logic [WordW-1:0] skip_cur;
    logic [WordW-1:0] len;
    logic [KindW-1:0] kind;
    logic [WordW+1:0] rec_end;
    logic             fits;
    logic             hit;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= FileLengthReset;
            max_payload_reg <= MaxPayloadReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgFileLength: file_length_reg <= cfg_data;
                CfgMaxPayload: max_payload_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // A file start clears the state before its byte is taken.
        fill_cur = item.file_start ? '0 : fill_reg;
        pos_cur  = item.file_start ? '0 : pos_reg;
        skip_cur = item.file_start ? '0 : skip_reg;

        pos_next  = (pos_cur == PosMax) ? pos_cur : pos_cur + 32'd1;
        skip_next = skip_cur;
        fill_next = fill_cur;
        win_next  = win_reg;

        len  = {item.data_byte, win_reg[6], win_reg[5], win_reg[4]};
        kind = match_magic({win_reg[0], win_reg[1], win_reg[2], win_reg[3]});

        // Header plus payload must end within the file: cur + 1 + len <= length.
        rec_end = {2'b00, pos_cur} + 34'd1 + {2'b00, len};
        fits = (len != '0) && (len <= max_payload_reg) && (pos_cur >= 32'(WinHeld))
            && (rec_end <= {2'b00, file_length_reg});
        hit = 1'b0;

        if (skip_cur != '0)
        begin
            skip_next = skip_cur - 32'd1;
        end
        else if (fill_cur != FillW'(WinHeld))
        begin
            for (int i = 0; i < WinHeld; i++)
            begin
                if (fill_cur == FillW'(i))
                begin
                    win_next[i] = item.data_byte;
                end
            end
            fill_next = fill_cur + FillW'(1);
        end
        else if ((kind != KindNone) && fits)
        begin
            hit       = 1'b1;
            fill_next = '0;
            skip_next = len;
        end
        else
        begin
            // Rejected window: drop the oldest byte.
            for (int i = 0; i < WinHeld - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[WinHeld - 1] = item.data_byte;
        end

        scan_out.emit               = go && hit;
        scan_out.rec.payload_offset = (pos_cur == PosMax) ? PosMax : pos_cur + 32'd1;
        scan_out.rec.payload_length = len;
        scan_out.rec.magic_kind     = kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            skip_reg <= '0;
        end
        else if (go)
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            skip_reg <= skip_next;
        end
    end

    // Window bytes past the fill count are never read, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            win_reg <= win_next;
        end
    end

endmodule

// ===== sv/bdf_out_reg.sv =====
// Result register of the deframer: holds one found record until the
// downstream side takes it. Depends on bdf_pkg.
module bdf_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bdf_pkg::bdf_scan_out_t scan_out,
    input  logic                   out_ready,
    output logic                   out_valid,
    output bdf_pkg::bdf_rec_t      rec
);
    import bdf_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    bdf_rec_t rec_reg;

    always_comb
    begin
        if (scan_out.emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_out.emit)
        begin
            rec_reg <= scan_out.rec;
        end
    end

    assign out_valid = valid_reg;
    assign rec       = rec_reg;

endmodule

// ===== sv/block_record_deframer_top.sv =====
// Block record deframer: finds magic-tagged, length-prefixed records in a byte stream.
// A record goes to the result register when its last header byte leaves the input register.
// One byte per cycle while not stalled; window, position and skip updates are combinational.
// A full result register that is not taken stalls the scanner and then the input.
// Reset (rst_n, asynchronous, active low) empties both stages, clears the window fill,
// position and skip counts and restores file_length to 0 and max_payload to 2000000.
module block_record_deframer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bdf_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [bdf_pkg::WordW-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bdf_pkg::ByteW-1:0]     data_byte,
    input  logic                          file_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bdf_pkg::WordW-1:0]     payload_offset,
    output logic [bdf_pkg::WordW-1:0]     payload_length,
    output logic [bdf_pkg::KindW-1:0]     magic_kind
);
    import bdf_pkg::*;

    bdf_item_t     item_in;
    bdf_item_t     item_held;
    logic          held_valid;
    logic          go;
    bdf_scan_out_t scan_out;
    bdf_rec_t      rec;

    // The held item is scanned whenever the result register is free or being
    // emptied in the same cycle; the input stage refills as it drains.
    assign go       = held_valid && (!out_valid || out_ready);
    assign in_ready = !held_valid || go;

    assign item_in.data_byte  = data_byte;
    assign item_in.file_start = file_start;

    bdf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_valid && in_ready),
        .take     (go),
        .item_in  (item_in),
        .valid    (held_valid),
        .item_out (item_held)
    );

    // The scanner owns all sequence state; it advances once per scanned item.
    bdf_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .go        (go),
        .item      (item_held),
        .scan_out  (scan_out)
    );

    bdf_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_out  (scan_out),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .rec       (rec)
    );

    assign payload_offset = rec.payload_offset;
    assign payload_length = rec.payload_length;
    assign magic_kind     = rec.magic_kind;

    // A record is only produced when the result register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_out.emit |-> (!out_valid || out_ready))
        else $error("record emitted into an occupied result register");

    // A record is only produced for an item the input stage held.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_out.emit |-> held_valid)
        else $error("record emitted without a held item");

    // Delivered records carry a real magic and a nonzero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (magic_kind != KindNone) && (payload_length != '0))
        else $error("record with no magic or zero length");

    // The payload always starts after a full eight-byte header.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (payload_offset >= 32'd8))
        else $error("payload offset inside the first header");

endmodule

// ===== bench/block_record_deframer_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for block_record_deframer_top: byte items in, record items out.
// Depends on bdf_pkg for port widths and config indexes, and on the top module itself.
module block_record_deframer_top_test;

    import bdf_pkg::*;

    // Magic kinds as the block reports them, and the header word for each kind with
    // the first file byte in the top byte.
    localparam logic [KindW-1:0] KindMagic24 = 2'd0;
    localparam logic [KindW-1:0] KindMagicFa = 2'd1;
    localparam logic [KindW-1:0] KindMagicAa = 2'd2;
    localparam logic [WordW-1:0] RecMagic [NumMagics] = '{
        32'h24e9_2764,
        32'hfa1a_f9bf,
        32'haae8_3f5f
    };

    // The config port decodes two index bits, so two indexes name no register at all.
    localparam logic [CfgIndexW-1:0] CfgUnusedLow = 2'd2;
    localparam logic [CfgIndexW-1:0] CfgUnusedHigh = 2'd3;

    // Anything still in flight only has the input and result registers to pass, so this
    // drain is enough for it to show up.
    localparam int unsigned DrainCycles = 6;
    // The longest legal silence is the receiver hold-off below; this leaves a wide margin.
    localparam int unsigned StallLimit = 2000;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned IdlePct = 18;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [WordW-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ByteW-1:0]     data_byte = '0;
    logic                 file_start = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [WordW-1:0]     payload_offset;
    logic [WordW-1:0]     payload_length;
    logic [KindW-1:0]     magic_kind;

    block_record_deframer_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .file_start     (file_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .magic_kind     (magic_kind)
    );

    always #2 clk = ~clk;

    // Shadow of the block's registers and scan state. The registers change only while
    // the block is idle, so the shadow copy is updated right at the write.
    logic [WordW-1:0] file_len_cfg = FileLengthReset;
    logic [WordW-1:0] max_pay_cfg = MaxPayloadReset;
    logic [ByteW-1:0] scan_win [8] = '{default: '0};
    int unsigned      scan_fill = 0;
    logic [WordW-1:0] scan_pos = '0;
    logic [WordW-1:0] skip_left = '0;

    // Records the block owes us, oldest first.
    bdf_rec_t due_records [$];

    // Sender and receiver behavior, changed by the tests as they go.
    int unsigned in_idle_pct = IdlePct;
    int unsigned out_idle_pct = IdlePct;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;

    // The next byte sent opens a new file; file_used counts bytes since the last start.
    logic        start_next = 1'b0;
    int unsigned file_used = 0;

    int unsigned bytes_sent = 0;
    int unsigned files_started = 0;
    int unsigned records_checked = 0;
    int unsigned err_cnt = 0;
    int unsigned stall_cycles = 0;

    // Steps the scan by one accepted byte and queues the record it completes, if any.
    task automatic scan_byte(input logic [ByteW-1:0] b, input logic fs);
        logic [WordW-1:0] cur;
        logic [WordW-1:0] len;
        logic [WordW-1:0] head;
        logic [KindW-1:0] kind;
        logic [63:0]      hdr;
        logic [63:0]      flen;
        logic [63:0]      off;
        logic             fits;
        bdf_rec_t         rec;
        if (fs)
        begin
            scan_win = '{default: '0};
            scan_fill = 0;
            scan_pos = '0;
            skip_left = '0;
        end
        cur = scan_pos;
        if (scan_pos != PosMax)
        begin
            scan_pos = scan_pos + 1;
        end
        // Payload bytes only count down; they never reach the window.
        if (skip_left != 0)
        begin
            skip_left = skip_left - 1;
            return;
        end
        if (scan_fill >= 8)
        begin
            scan_fill = 7;
        end
        scan_win[scan_fill[2:0]] = b;
        scan_fill++;
        if (scan_fill < 8)
        begin
            return;
        end
        head = {scan_win[0], scan_win[1], scan_win[2], scan_win[3]};
        len = {scan_win[7], scan_win[6], scan_win[5], scan_win[4]};
        kind = KindNone;
        for (int k = 0; k < NumMagics; k++)
        begin
            if (kind == KindNone && head == RecMagic[k])
            begin
                kind = KindW'(k);
            end
        end
        // The header began seven bytes back; it and its payload must lie in the file.
        hdr = {32'd0, cur} - 64'd7;
        flen = {32'd0, file_len_cfg};
        fits = (len != 0) && (len <= max_pay_cfg) && (hdr <= flen) && (flen - hdr >= 64'd8)
            && ({32'd0, len} <= flen - hdr - 64'd8);
        if (kind != KindNone && fits)
        begin
            off = hdr + 64'd8;
            rec.payload_offset = (off > {32'd0, PosMax}) ? PosMax : off[WordW-1:0];
            rec.payload_length = len;
            rec.magic_kind = kind;
            due_records.push_back(rec);
            scan_win = '{default: '0};
            scan_fill = 0;
            skip_left = len;
            return;
        end
        // A rejected window drops its oldest byte and the scan moves on by one.
        for (int i = 0; i < 7; i++)
        begin
            scan_win[i] = scan_win[i + 1];
        end
        scan_win[7] = '0;
        scan_fill = 7;
    endtask

    // Every byte the block takes goes through the scan shadow at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            scan_byte(data_byte, file_start);
        end
    end

    // Each record the block hands over must match the oldest one owed, field by field.
    always @(posedge clk)
    begin
        bdf_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            records_checked++;
            if (due_records.size() == 0)
            begin
                $error("unexpected record: offset %0h length %0h kind %0d",
                    payload_offset, payload_length, magic_kind);
                err_cnt++;
            end
            else
            begin
                want = due_records.pop_front();
                if (payload_offset !== want.payload_offset)
                begin
                    $error("payload_offset: expected %0h, got %0h",
                        want.payload_offset, payload_offset);
                    err_cnt++;
                end
                if (payload_length !== want.payload_length)
                begin
                    $error("payload_length: expected %0h, got %0h",
                        want.payload_length, payload_length);
                    err_cnt++;
                end
                if (magic_kind !== want.magic_kind)
                begin
                    $error("magic_kind: expected %0d, got %0d", want.magic_kind, magic_kind);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one. The
    // hold-off is counted here so the sender can keep pushing items meanwhile.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Watchdog: too many cycles with no handshake on any port means the block hung.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one byte, with a random gap first, and returns at the edge that takes it.
    // Valid is left high, so back-to-back calls keep the stream dense.
    task automatic send_byte(input logic [ByteW-1:0] b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (start_next)
        begin
            file_used = 0;
            files_started++;
        end
        in_valid <= 1'b1;
        data_byte <= b;
        file_start <= start_next;
        start_next = 1'b0;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        file_used++;
        bytes_sent++;
    endtask

    // Magic bytes in file order, then the length least significant byte first.
    task automatic send_header(input logic [WordW-1:0] head, input logic [WordW-1:0] len);
        for (int i = 3; i >= 0; i--)
        begin
            send_byte(head[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_byte(len[8*i +: 8]);
        end
    endtask

    task automatic send_record(input logic [KindW-1:0] kind, input logic [WordW-1:0] len,
                               input int unsigned n_payload);
        send_header(RecMagic[kind], len);
        repeat (n_payload)
        begin
            send_byte(8'($urandom));
        end
    endtask

    // Stops offering and waits until every owed record is back and the pipe is empty.
    task automatic drain_records();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_records.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles)
        begin
            @(posedge clk);
        end
    endtask

    // Call only while the block is idle. cfg_we is dropped again after each write.
    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [WordW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CfgFileLength)
        begin
            file_len_cfg = val;
        end
        else if (idx == CfgMaxPayload)
        begin
            max_pay_cfg = val;
        end
        @(posedge clk);
    endtask

    // Random files: mostly well-formed records with random payload, mixed with noise,
    // partial magics, broken headers, huge lengths and fresh file starts.
    task automatic send_random_stream(input int unsigned n_bytes, input int unsigned len_cap);
        int unsigned      stop_at;
        int unsigned      pick;
        int unsigned      n_head;
        longint           room;
        longint           top;
        logic [KindW-1:0] kind;
        logic [WordW-1:0] head;
        logic [WordW-1:0] len;
        stop_at = bytes_sent + n_bytes;
        start_next = 1'b1;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            kind = KindW'($urandom_range(NumMagics - 1));
            head = RecMagic[kind];
            room = longint'(file_len_cfg) - (start_next ? 0 : longint'(file_used)) - 8;
            if (pick < 55)
            begin
                repeat ($urandom_range(3))
                begin
                    send_byte(8'($urandom));
                end
                room = longint'(file_len_cfg) - longint'(file_used) - 8;
                if (room < 1)
                begin
                    // No room left in this file, so the record opens the next one.
                    start_next = 1'b1;
                    room = longint'(file_len_cfg) - 8;
                end
                top = len_cap;
                if (top > longint'(max_pay_cfg))
                begin
                    top = max_pay_cfg;
                end
                if (top > room)
                begin
                    top = room;
                end
                len = (top < 1) ? 32'd1 : 32'($urandom_range(1, int'(top)));
                send_record(kind, len, len);
            end
            else if (pick < 60)
            begin
                // A length this big leaves the scan skipping until the next file start.
                len = $urandom | 32'h0100_0000;
                send_record(kind, len, $urandom_range(4, 12));
                start_next = 1'b1;
            end
            else if (pick < 80)
            begin
                len = 32'($urandom_range(1, len_cap));
                case ($urandom_range(3))
                    0: head = head ^ (32'd1 << $urandom_range(31));
                    1: len = '0;
                    2: len = max_pay_cfg + 32'd1;
                    default: len = (room < 0) ? 32'd1 : 32'(room + 1);
                endcase
                send_header(head, len);
                repeat ($urandom_range(4))
                begin
                    send_byte(8'($urandom));
                end
            end
            else if (pick < 92)
            begin
                // Noise, sometimes opening with the start of a magic that never completes.
                n_head = ($urandom_range(1) == 1) ? $urandom_range(1, 3) : 0;
                for (int i = 0; i < n_head; i++)
                begin
                    send_byte(head[31 - 8*i -: 8]);
                end
                repeat ($urandom_range(1, 10))
                begin
                    send_byte(8'($urandom));
                end
            end
            else
            begin
                start_next = 1'b1;
            end
        end
    endtask

    // Reset values: an empty file accepts nothing, and max_payload starts at 2000000.
    task automatic test_reset_defaults();
        send_record(KindMagic24, 32'd1, 1);
        drain_records();
        write_reg(CfgFileLength, PosMax);
        start_next = 1'b1;
        send_header(RecMagic[KindMagicFa], MaxPayloadReset + 32'd1);
        send_header(RecMagic[KindMagic24], MaxPayloadReset);
        // The accepted record leaves a long skip behind; the next file start ends it.
        drain_records();
    endtask

    // Header rules in a 28-byte file: a good record, a zero length, a record that ends
    // exactly at the file end with the largest length allowed, and a header past the end.
    // Writes to the two unused indexes come before the stream and must change nothing.
    task automatic test_header_rules();
        write_reg(CfgFileLength, 32'd28);
        write_reg(CfgMaxPayload, 32'd3);
        write_reg(CfgUnusedLow, 32'd0);
        write_reg(CfgUnusedHigh, 32'd0);
        start_next = 1'b1;
        send_header(RecMagic[KindMagic24], 32'd1);
        send_byte(8'hff);
        send_header(RecMagic[KindMagicFa], 32'd0);
        send_header(RecMagic[KindMagicAa], 32'd3);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7f);
        send_header(RecMagic[KindMagic24], 32'd1);
        drain_records();
    endtask

    // A max_payload of 1 in the largest file, then a file start in a half-built window.
    task automatic test_length_limits();
        write_reg(CfgFileLength, PosMax);
        write_reg(CfgMaxPayload, 32'd1);
        start_next = 1'b1;
        send_header(RecMagic[KindMagicFa], 32'd2);
        send_record(KindMagic24, 32'd1, 1);
        send_byte(8'haa);
        send_byte(8'he8);
        send_byte(8'h3f);
        start_next = 1'b1;
        send_record(KindMagicAa, 32'd1, 1);
        drain_records();
    endtask

    // The longest length that fits the largest file, with a header hidden in its payload,
    // then a file start that abandons the skip.
    task automatic test_skip_abort();
        write_reg(CfgMaxPayload, PosMax);
        start_next = 1'b1;
        send_header(RecMagic[KindMagicAa], 32'hffff_fff7);
        send_header(RecMagic[KindMagic24], 32'd1);
        start_next = 1'b1;
        send_record(KindMagicFa, 32'd1, 1);
        drain_records();
    endtask

    task automatic test_random_records();
        write_reg(CfgFileLength, 32'd600);
        write_reg(CfgMaxPayload, 32'd40);
        send_random_stream(520, 24);
        drain_records();
    endtask

    task automatic test_random_wide();
        write_reg(CfgFileLength, PosMax);
        write_reg(CfgMaxPayload, PosMax);
        send_random_stream(350, 40);
        drain_records();
    endtask

    // A dense stretch: neither side idles at all.
    task automatic test_no_idle();
        write_reg(CfgFileLength, 32'd150);
        write_reg(CfgMaxPayload, 32'd12);
        in_idle_pct = 0;
        out_idle_pct = 0;
        send_random_stream(200, 12);
        drain_records();
        in_idle_pct = IdlePct;
        out_idle_pct = IdlePct;
    endtask

    // The receiver holds off while short records keep coming, so the result register and
    // input stage fill up and the block has to stall its input.
    task automatic test_backpressure();
        write_reg(CfgFileLength, 32'd4000);
        write_reg(CfgMaxPayload, 32'd40);
        in_idle_pct = 0;
        hold_request = HoldCycles;
        start_next = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            send_record(KindW'(i % NumMagics), 32'd1, 1);
        end
        drain_records();
        in_idle_pct = IdlePct;
    endtask

    // With a zero file length every header fails the size check.
    task automatic test_empty_file();
        write_reg(CfgFileLength, 32'd0);
        send_random_stream(60, 8);
        drain_records();
    endtask

    initial
    begin
        repeat (5)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_header_rules();
        test_length_limits();
        test_skip_abort();
        test_random_records();
        test_random_wide();
        test_no_idle();
        test_backpressure();
        test_empty_file();

        drain_records();
        $display("Scanned %0d bytes in %0d files; %0d records came back and were compared.",
            bytes_sent, files_started, records_checked);
        $display("Register settings ranged from empty to full-size files and payload limits.");
        if (err_cnt == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
